// ===== rtl/flpm_pkg.sv =====
// Shared types and constants of the four-lane rotating phasor mixer.
// No dependencies; imported by every module of the block.
package flpm_pkg;

    // Fixed sample width of the request and result payloads
    localparam int SAMPLE_W      = 16;
    // Default phasor fraction width (phasor is PHASOR_FRAC_W + 2 bits)
    localparam int PHASOR_FRAC_W = 16;
    localparam int NUM_LANES     = 4;
    localparam int NUM_REGS      = 8;
    localparam int CFG_IDX_W     = $clog2(NUM_REGS);

    // Configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_RE     = 3'd0,
        REG_STEP_IM     = 3'd1,
        REG_LANE1_RE    = 3'd2,
        REG_LANE1_IM    = 3'd3,
        REG_LANE2_RE    = 3'd4,
        REG_LANE2_IM    = 3'd5,
        REG_LANE3_RE    = 3'd6,
        REG_LANE3_IM    = 3'd7
    } cfg_idx_t;

    // Four consecutive complex input samples
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] in0_re;
        logic signed [SAMPLE_W-1:0] in0_im;
        logic signed [SAMPLE_W-1:0] in1_re;
        logic signed [SAMPLE_W-1:0] in1_im;
        logic signed [SAMPLE_W-1:0] in2_re;
        logic signed [SAMPLE_W-1:0] in2_im;
        logic signed [SAMPLE_W-1:0] in3_re;
        logic signed [SAMPLE_W-1:0] in3_im;
    } mix_in_t;

    // Four mixed complex output samples
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out0_re;
        logic signed [SAMPLE_W-1:0] out0_im;
        logic signed [SAMPLE_W-1:0] out1_re;
        logic signed [SAMPLE_W-1:0] out1_im;
        logic signed [SAMPLE_W-1:0] out2_re;
        logic signed [SAMPLE_W-1:0] out2_im;
        logic signed [SAMPLE_W-1:0] out3_re;
        logic signed [SAMPLE_W-1:0] out3_im;
    } mix_out_t;

    // Control from the register file to the lanes
    typedef struct packed {
        logic reload;
    } cfg_ctl_t;

endpackage

// ===== rtl/four_lane_rotating_phasor_mixer.sv =====
// Top level of the four-lane rotating phasor complex mixer.
// Depends on flpm_pkg, flpm_cfg and flpm_lane.
//
//   channel   signals                                  direction  handshake
//   --------  ---------------------------------------  ---------  -----------------
//   sample    sample_valid, sample_stall, sample        in         valid / stall
//   mixed     mixed_valid, mixed_stall, mixed           out        valid / stall
//   cfg       cfg_valid, cfg_ready, cfg_index, cfg_data in         valid / ready
//
// Flow: one request per clock while mixed_stall is low; a request lands
//   in the input register, then the lane multipliers and the phasor
//   rotation (one multiply deep) fill the result register once it is free.
// Reset: registers to 1.0 / 0, all lane phasors to 1.0 + 0j.
// Stalls: sample_stall rises only when both registers are full and
//   mixed_stall is high. cfg_ready is always high; a write reloads the lane
//   phasors on the following cycle.
module four_lane_rotating_phasor_mixer import flpm_pkg::*;
#(
    parameter int PHASOR_FRAC_BITS = PHASOR_FRAC_W
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    // request channel
    input  logic                               sample_valid,
    output logic                               sample_stall,
    input  mix_in_t                            sample,
    // result channel
    output logic                               mixed_valid,
    input  logic                               mixed_stall,
    output mix_out_t                           mixed,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [CFG_IDX_W-1:0]               cfg_index,
    input  logic signed [PHASOR_FRAC_BITS+1:0] cfg_data
);

    localparam int PW = PHASOR_FRAC_BITS + 2;
    localparam logic signed [PW-1:0] PH_ONE = PW'(1) <<< PHASOR_FRAC_BITS;

    // Pipeline registers
    mix_in_t  in_reg, in_next;
    logic     in_vld_reg, in_vld_next;
    mix_out_t out_reg, out_next;
    logic     out_vld_reg, out_vld_next;

    logic     sample_acc;
    logic     out_load;     // input register moves into result register

    // Configuration
    logic                 cfg_wr;
    cfg_ctl_t             cfg_ctl;
    logic signed [PW-1:0] step_re, step_im;
    logic signed [PW-1:0] cfg_start_re [1:NUM_LANES-1];
    logic signed [PW-1:0] cfg_start_im [1:NUM_LANES-1];
    logic signed [PW-1:0] lane_start_re [NUM_LANES];
    logic signed [PW-1:0] lane_start_im [NUM_LANES];

    // Per-lane sample and mixed values
    logic signed [SAMPLE_W-1:0] smp_re [NUM_LANES];
    logic signed [SAMPLE_W-1:0] smp_im [NUM_LANES];
    logic signed [SAMPLE_W-1:0] mix_re [NUM_LANES];
    logic signed [SAMPLE_W-1:0] mix_im [NUM_LANES];

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid & cfg_ready;

    flpm_cfg #(
        .PHASOR_FRAC_BITS (PHASOR_FRAC_BITS)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_wr),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .step_re  (step_re),
        .step_im  (step_im),
        .start_re (cfg_start_re),
        .start_im (cfg_start_im),
        .ctl      (cfg_ctl)
    );

    // Lane 0 always restarts at 1.0 + 0j
    always_comb
    begin
        lane_start_re[0] = PH_ONE;
        lane_start_im[0] = '0;
        for (int k = 1; k < NUM_LANES; k++)
        begin
            lane_start_re[k] = cfg_start_re[k];
            lane_start_im[k] = cfg_start_im[k];
        end
    end

    // Handshake: the result register frees whenever it is empty or drained
    assign out_load     = in_vld_reg & ~(out_vld_reg & mixed_stall);
    assign sample_stall = in_vld_reg & ~out_load;
    assign sample_acc   = sample_valid & ~sample_stall;

    // Unpack the request register into lanes
    assign smp_re[0] = in_reg.in0_re;
    assign smp_im[0] = in_reg.in0_im;
    assign smp_re[1] = in_reg.in1_re;
    assign smp_im[1] = in_reg.in1_im;
    assign smp_re[2] = in_reg.in2_re;
    assign smp_im[2] = in_reg.in2_im;
    assign smp_re[3] = in_reg.in3_re;
    assign smp_im[3] = in_reg.in3_im;

    // Each lane rotates its phasor as its sample leaves the input register
    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        flpm_lane #(
            .SAMPLE_BITS      (SAMPLE_W),
            .PHASOR_FRAC_BITS (PHASOR_FRAC_BITS)
        ) u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .reload   (cfg_ctl.reload),
            .advance  (out_load),
            .start_re (lane_start_re[g]),
            .start_im (lane_start_im[g]),
            .step_re  (step_re),
            .step_im  (step_im),
            .smp_re   (smp_re[g]),
            .smp_im   (smp_im[g]),
            .mix_re   (mix_re[g]),
            .mix_im   (mix_im[g])
        );
    end

    always_comb
    begin
        in_next     = sample_acc ? sample : in_reg;
        in_vld_next = sample_acc ? 1'b1 : (out_load ? 1'b0 : in_vld_reg);

        out_next = out_reg;
        if (out_load)
        begin
            out_next.out0_re = mix_re[0];
            out_next.out0_im = mix_im[0];
            out_next.out1_re = mix_re[1];
            out_next.out1_im = mix_im[1];
            out_next.out2_re = mix_re[2];
            out_next.out2_im = mix_im[2];
            out_next.out3_re = mix_re[3];
            out_next.out3_im = mix_im[3];
        end
        out_vld_next = out_load ? 1'b1 : (mixed_stall ? out_vld_reg : 1'b0);
    end

    // Payload registers carry no reset
    always_ff @(posedge clk)
    begin
        in_reg  <= in_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    assign mixed_valid = out_vld_reg;
    assign mixed       = out_reg;

    // Back-pressure only when both stages are full and the sink holds off
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> (in_vld_reg && out_vld_reg && mixed_stall))
        else $error("request stalled with room in the pipeline");

    // A held request moves on once the result register can take it
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !(out_vld_reg && mixed_stall)) |=> out_vld_reg)
        else $error("request left the input register without a result");

    // Every register write triggers a phasor reload next cycle
    a_reload: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> cfg_ctl.reload)
        else $error("register write without phasor reload");

endmodule

// ===== rtl/flpm_cfg.sv =====
// Configuration register file: step phasor and start phasors of lanes 1..3.
// Depends on flpm_pkg. Flags a phasor reload in the cycle after any write.
module flpm_cfg import flpm_pkg::*;
#(
    parameter int PHASOR_FRAC_BITS = PHASOR_FRAC_W
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [CFG_IDX_W-1:0]             wr_index,
    input  logic signed [PHASOR_FRAC_BITS+1:0] wr_data,
    output logic signed [PHASOR_FRAC_BITS+1:0] step_re,
    output logic signed [PHASOR_FRAC_BITS+1:0] step_im,
    output logic signed [PHASOR_FRAC_BITS+1:0] start_re [1:NUM_LANES-1],
    output logic signed [PHASOR_FRAC_BITS+1:0] start_im [1:NUM_LANES-1],
    output cfg_ctl_t                         ctl
);

    localparam int PW = PHASOR_FRAC_BITS + 2;
    localparam logic signed [PW-1:0] PH_ONE = PW'(1) <<< PHASOR_FRAC_BITS;

    logic signed [PW-1:0] step_re_reg, step_re_next;
    logic signed [PW-1:0] step_im_reg, step_im_next;
    logic signed [PW-1:0] start_re_reg  [1:NUM_LANES-1];
    logic signed [PW-1:0] start_re_next [1:NUM_LANES-1];
    logic signed [PW-1:0] start_im_reg  [1:NUM_LANES-1];
    logic signed [PW-1:0] start_im_next [1:NUM_LANES-1];
    logic                 reload_reg;

    always_comb
    begin
        step_re_next  = step_re_reg;
        step_im_next  = step_im_reg;
        start_re_next = start_re_reg;
        start_im_next = start_im_reg;
        if (wr_en)
        begin
            case (cfg_idx_t'(wr_index))
                REG_STEP_RE:  step_re_next     = wr_data;
                REG_STEP_IM:  step_im_next     = wr_data;
                REG_LANE1_RE: start_re_next[1] = wr_data;
                REG_LANE1_IM: start_im_next[1] = wr_data;
                REG_LANE2_RE: start_re_next[2] = wr_data;
                REG_LANE2_IM: start_im_next[2] = wr_data;
                REG_LANE3_RE: start_re_next[3] = wr_data;
                REG_LANE3_IM: start_im_next[3] = wr_data;
                default:      step_re_next     = step_re_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_re_reg <= PH_ONE;
            step_im_reg <= '0;
            for (int k = 1; k < NUM_LANES; k++)
            begin
                start_re_reg[k] <= PH_ONE;
                start_im_reg[k] <= '0;
            end
            reload_reg <= 1'b0;
        end
        else
        begin
            step_re_reg  <= step_re_next;
            step_im_reg  <= step_im_next;
            start_re_reg <= start_re_next;
            start_im_reg <= start_im_next;
            reload_reg   <= wr_en;
        end
    end

    assign step_re    = step_re_reg;
    assign step_im    = step_im_reg;
    assign start_re   = start_re_reg;
    assign start_im   = start_im_reg;
    assign ctl.reload = reload_reg;

endmodule

// ===== rtl/flpm_lane.sv =====
// One mixer lane: holds the lane phasor, forms the rounded, saturated
// sample product and the rotated phasor. Depends on flpm_pkg.
module flpm_lane import flpm_pkg::*;
#(
    parameter int SAMPLE_BITS      = SAMPLE_W,
    parameter int PHASOR_FRAC_BITS = PHASOR_FRAC_W
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               reload,
    input  logic                               advance,
    input  logic signed [PHASOR_FRAC_BITS+1:0] start_re,
    input  logic signed [PHASOR_FRAC_BITS+1:0] start_im,
    input  logic signed [PHASOR_FRAC_BITS+1:0] step_re,
    input  logic signed [PHASOR_FRAC_BITS+1:0] step_im,
    input  logic signed [SAMPLE_BITS-1:0]      smp_re,
    input  logic signed [SAMPLE_BITS-1:0]      smp_im,
    output logic signed [SAMPLE_BITS-1:0]      mix_re,
    output logic signed [SAMPLE_BITS-1:0]      mix_im
);

    localparam int PW   = PHASOR_FRAC_BITS + 2;
    localparam int SPW  = SAMPLE_BITS + PW;     // sample x phasor product
    localparam int SACC = SPW + 1;
    localparam int PPW  = 2 * PW;               // phasor x step product
    localparam int PACC = PPW + 1;

    localparam logic signed [PW-1:0]   PH_ONE = PW'(1) <<< PHASOR_FRAC_BITS;
    localparam logic signed [SACC-1:0] S_RND  = SACC'(1) <<< (PHASOR_FRAC_BITS - 1);
    localparam logic signed [SACC-1:0] S_MAX  = (SACC'(1) <<< (SAMPLE_BITS - 1)) - SACC'(1);
    localparam logic signed [SACC-1:0] S_MIN  = -(SACC'(1) <<< (SAMPLE_BITS - 1));
    localparam logic signed [PACC-1:0] P_RND  = PACC'(1) <<< (PHASOR_FRAC_BITS - 1);
    localparam logic signed [PACC-1:0] P_MAX  = (PACC'(1) <<< (PW - 1)) - PACC'(1);
    localparam logic signed [PACC-1:0] P_MIN  = -(PACC'(1) <<< (PW - 1));

    // Round half up, drop the fraction, clamp to the sample range
    function automatic logic signed [SAMPLE_BITS-1:0] smp_round(
        input logic signed [SACC-1:0] acc);
        logic signed [SACC-1:0] q;
        q = (acc + S_RND) >>> PHASOR_FRAC_BITS;
        if (q > S_MAX)
            return SAMPLE_BITS'(S_MAX);
        else if (q < S_MIN)
            return SAMPLE_BITS'(S_MIN);
        else
            return SAMPLE_BITS'(q);
    endfunction

    function automatic logic signed [PW-1:0] ph_round(
        input logic signed [PACC-1:0] acc);
        logic signed [PACC-1:0] q;
        q = (acc + P_RND) >>> PHASOR_FRAC_BITS;
        if (q > P_MAX)
            return PW'(P_MAX);
        else if (q < P_MIN)
            return PW'(P_MIN);
        else
            return PW'(q);
    endfunction

    logic signed [PW-1:0]  ph_re_reg, ph_re_next;
    logic signed [PW-1:0]  ph_im_reg, ph_im_next;
    logic signed [SPW-1:0] p_rr, p_ii, p_ri, p_ir;
    logic signed [PPW-1:0] q_rr, q_ii, q_ri, q_ir;
    logic signed [PW-1:0]  rot_re, rot_im;

    // Sample times phasor
    assign p_rr = SPW'(smp_re) * SPW'(ph_re_reg);
    assign p_ii = SPW'(smp_im) * SPW'(ph_im_reg);
    assign p_ri = SPW'(smp_re) * SPW'(ph_im_reg);
    assign p_ir = SPW'(smp_im) * SPW'(ph_re_reg);

    assign mix_re = smp_round(SACC'(p_rr) - SACC'(p_ii));
    assign mix_im = smp_round(SACC'(p_ri) + SACC'(p_ir));

    // Phasor times step, no renormalization
    assign q_rr = PPW'(ph_re_reg) * PPW'(step_re);
    assign q_ii = PPW'(ph_im_reg) * PPW'(step_im);
    assign q_ri = PPW'(ph_re_reg) * PPW'(step_im);
    assign q_ir = PPW'(ph_im_reg) * PPW'(step_re);

    assign rot_re = ph_round(PACC'(q_rr) - PACC'(q_ii));
    assign rot_im = ph_round(PACC'(q_ri) + PACC'(q_ir));

    always_comb
    begin
        ph_re_next = ph_re_reg;
        ph_im_next = ph_im_reg;
        if (reload)
        begin
            ph_re_next = start_re;
            ph_im_next = start_im;
        end
        else if (advance)
        begin
            ph_re_next = rot_re;
            ph_im_next = rot_im;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_re_reg <= PH_ONE;
            ph_im_reg <= '0;
        end
        else
        begin
            ph_re_reg <= ph_re_next;
            ph_im_reg <= ph_im_next;
        end
    end

endmodule

// ===== verif/flpm_mixer_checker.sv =====
`timescale 1ns / 100ps
// Result checker of the four-lane rotating phasor mixer: it holds its own mixer
// state, predicts each result and compares it with what the block returns.
// Depends on flpm_pkg only.
module flpm_mixer_checker import flpm_pkg::*;
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             sample_valid,
    input  logic                             sample_stall,
    input  mix_in_t                          sample,
    input  logic                             mixed_valid,
    input  logic                             mixed_stall,
    input  mix_out_t                         mixed,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [CFG_IDX_W-1:0]             cfg_index,
    input  logic signed [PHASOR_FRAC_W+1:0]  cfg_data,
    output int                               fails,
    output int                               pending,
    output int                               results_seen
);

    localparam int     PH_W        = PHASOR_FRAC_W + 2;
    localparam longint ONE         = longint'(1) <<< PHASOR_FRAC_W;
    localparam longint HALF_LSB    = longint'(1) <<< (PHASOR_FRAC_W - 1);

    typedef logic signed [PH_W-1:0] ph_word_t;
    typedef logic [2*NUM_LANES-1:0][SAMPLE_W-1:0] lane_words_t;

    ph_word_t cfg_reg [NUM_REGS];
    ph_word_t ph_re   [NUM_LANES];
    ph_word_t ph_im   [NUM_LANES];
    mix_out_t mix_expected [$];
    mix_out_t want;

    // round to nearest, ties up, of (a + b) / 2^F
    function automatic longint round_frac(input longint a, input longint b);
        return (a + b + HALF_LSB) >>> PHASOR_FRAC_W;
    endfunction

    function automatic longint clamp_to(input longint v, input int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    task automatic reload_phasors();
        ph_re[0] = ph_word_t'(ONE);
        ph_im[0] = '0;
        ph_re[1] = cfg_reg[REG_LANE1_RE];
        ph_im[1] = cfg_reg[REG_LANE1_IM];
        ph_re[2] = cfg_reg[REG_LANE2_RE];
        ph_im[2] = cfg_reg[REG_LANE2_IM];
        ph_re[3] = cfg_reg[REG_LANE3_RE];
        ph_im[3] = cfg_reg[REG_LANE3_IM];
    endtask

    // mix four lanes with their phasors, then advance every phasor by the step
    function automatic mix_out_t mix_and_rotate(input mix_in_t x);
        lane_words_t src;
        lane_words_t dst;
        longint s_re, s_im, p_re, p_im, st_re, st_im, o_re, o_im;
        int k;
        int hi;
        src   = lane_words_t'(x);
        st_re = cfg_reg[REG_STEP_RE];
        st_im = cfg_reg[REG_STEP_IM];
        for (k = 0; k < NUM_LANES; k++)
        begin
            hi   = 2 * NUM_LANES - 1 - 2 * k;
            s_re = $signed(src[hi]);
            s_im = $signed(src[hi-1]);
            p_re = ph_re[k];
            p_im = ph_im[k];
            o_re = clamp_to(round_frac(s_re * p_re, -(s_im * p_im)), SAMPLE_W);
            o_im = clamp_to(round_frac(s_re * p_im, s_im * p_re), SAMPLE_W);
            dst[hi]   = o_re[SAMPLE_W-1:0];
            dst[hi-1] = o_im[SAMPLE_W-1:0];
            ph_re[k] = ph_word_t'(clamp_to(round_frac(p_re * st_re, -(p_im * st_im)), PH_W));
            ph_im[k] = ph_word_t'(clamp_to(round_frac(p_re * st_im, p_im * st_re), PH_W));
        end
        return mix_out_t'(dst);
    endfunction

    task automatic compare_result(input mix_out_t exp_val, input mix_out_t got_val);
        lane_words_t w;
        lane_words_t g;
        int j;
        int idx;
        w = lane_words_t'(exp_val);
        g = lane_words_t'(got_val);
        for (j = 0; j < 2 * NUM_LANES; j++)
        begin
            idx = 2 * NUM_LANES - 1 - j;
            if (g[idx] !== w[idx])
            begin
                fails++;
                $display("%0t ns: result %0d out%0d_%s expected %0d, actual %0d",
                         $time, results_seen, j / 2, (j % 2) ? "im" : "re",
                         $signed(w[idx]), $signed(g[idx]));
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
                cfg_reg[i] = (i % 2) ? ph_word_t'(0) : ph_word_t'(ONE);
            reload_phasors();
            mix_expected.delete();
            fails        = 0;
            results_seen = 0;
            pending     <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                cfg_reg[cfg_index] = cfg_data;
                reload_phasors();
            end
            // results first, so a request accepted at this edge can never cover one
            if (mixed_valid && !mixed_stall)
            begin
                if (mix_expected.size() == 0)
                begin
                    fails++;
                    $display("%0t ns: result %0d with no request outstanding, actual %h",
                             $time, results_seen, mixed);
                end
                else
                begin
                    want = mix_expected.pop_front();
                    compare_result(want, mixed);
                end
                results_seen++;
            end
            if (sample_valid && !sample_stall)
                mix_expected.push_back(mix_and_rotate(sample));
            pending <= mix_expected.size();
        end
    end

endmodule

// ===== verif/tb_four_lane_rotating_phasor_mixer.sv =====
`timescale 1ns / 100ps
// Testbench top of the four-lane rotating phasor mixer: clock, reset, request
// and register stimulus, result back-pressure and the final verdict.
// Depends on flpm_pkg, the mixer RTL and flpm_mixer_checker.
module tb_four_lane_rotating_phasor_mixer;
    import flpm_pkg::*;

    localparam int PH_W          = PHASOR_FRAC_W + 2;
    localparam int ONE           = 1 << PHASOR_FRAC_W;
    localparam int HALF_ONE      = ONE / 2;
    localparam int PH_MAX        = (1 << (PH_W - 1)) - 1;
    localparam int PH_MIN        = -(1 << (PH_W - 1));
    localparam int COS45         = 46341;
    // settle time after a drain and after register writes
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 8;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_ITEMS   = 150;
    // phase that sees the long result hold-off, and the one with a drain pause
    localparam int PRESSURE_PHASE = 2;
    localparam int PRESSURE_AT    = 30;
    localparam int PRESSURE_ITEMS = 60;
    localparam int LONG_HOLD      = 200;
    localparam int DRAIN_PHASE    = 5;
    localparam int DRAIN_AT       = 75;
    localparam int SINGLE_WRITE_PHASE = 4;
    // worst case is far below this limit with a 4 ns clock
    localparam int TIMEOUT_NS     = 4000000;

    typedef logic signed [PH_W-1:0] ph_word_t;

    logic                    clk          = 1'b0;
    logic                    rst_n        = 1'b0;
    logic                    sample_valid = 1'b0;
    logic                    sample_stall;
    mix_in_t                 sample       = '0;
    logic                    mixed_valid;
    logic                    mixed_stall  = 1'b0;
    mix_out_t                mixed;
    logic                    cfg_valid    = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index    = REG_STEP_RE;
    logic signed [PH_W-1:0]  cfg_data     = '0;

    int fails;
    int pending;
    int results_seen;

    // stimulus bookkeeping
    int items_sent    = 0;
    int cfg_writes    = 0;
    int settings_used = 1;   // the reset setting counts as the first
    // long hold-off hand-off: stimulus bumps hold_ask, result sink answers
    int hold_ask      = 0;
    int hold_done     = 0;

    ph_word_t next_setting [NUM_REGS];

    four_lane_rotating_phasor_mixer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .mixed_valid  (mixed_valid),
        .mixed_stall  (mixed_stall),
        .mixed        (mixed),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    flpm_mixer_checker mix_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .mixed_valid  (mixed_valid),
        .mixed_stall  (mixed_stall),
        .mixed        (mixed),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fails        (fails),
        .pending      (pending),
        .results_seen (results_seen)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    // ---------------------------------------------------------------
    // random lengths
    // ---------------------------------------------------------------

    // sender gap: half none, mostly short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int stall_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        if (r < 95)
            return $urandom_range(3, 10);
        return $urandom_range(20, 60);
    endfunction

    // ready stretches, sometimes long enough to run the block flat out
    function automatic int ready_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(1, 6);
        if (r < 90)
            return $urandom_range(7, 30);
        return $urandom_range(40, 120);
    endfunction

    // ---------------------------------------------------------------
    // value generators
    // ---------------------------------------------------------------

    // one sample word: extremes and small values show up often
    function automatic logic [SAMPLE_W-1:0] draw_word();
        int r;
        logic [SAMPLE_W-1:0] w;
        r = $urandom_range(0, 9);
        case (r)
            0:       w = 16'h7FFF;
            1:       w = 16'h8000;
            2:       w = SAMPLE_W'($urandom_range(0, 16) - 8);
            default: w = SAMPLE_W'($urandom);
        endcase
        return w;
    endfunction

    function automatic mix_in_t draw_sample();
        logic [2*NUM_LANES-1:0][SAMPLE_W-1:0] w;
        for (int i = 0; i < 2 * NUM_LANES; i++)
            w[i] = draw_word();
        return mix_in_t'(w);
    endfunction

    // cos of a multiple of 45 degrees in phasor units; sin(a) = cos(a - 2)
    function automatic int cos45(input int a);
        case (a % 8)
            0:       return ONE;
            1:       return COS45;
            2:       return 0;
            3:       return -COS45;
            4:       return -ONE;
            5:       return -COS45;
            6:       return 0;
            default: return COS45;
        endcase
    endfunction

    // fill next_setting: 0 near-unit rotations, 1 uniform within +-1.0,
    // 2 anything the 18-bit field holds, 3 corner values only
    task automatic draw_setting(input int kind);
        int a;
        int jit_re;
        int jit_im;
        int im;
        for (int k = 0; k < NUM_REGS / 2; k++)
        begin
            case (kind)
                0:
                begin
                    if (k == 0 && $urandom_range(0, 1))
                    begin
                        // slow tone: small angle, magnitude at or just over one
                        im = $urandom_range(0, 4000) - 2000;
                        next_setting[0] = ph_word_t'(ONE - (im * im) / (2 * ONE));
                        next_setting[1] = ph_word_t'(im);
                    end
                    else
                    begin
                        a      = $urandom_range(0, 7);
                        jit_re = $urandom_range(0, 64) - 32;
                        jit_im = $urandom_range(0, 64) - 32;
                        next_setting[2*k]   = ph_word_t'(cos45(a) + jit_re);
                        next_setting[2*k+1] = ph_word_t'(cos45(a + 6) + jit_im);
                    end
                end
                1:
                begin
                    next_setting[2*k]   = ph_word_t'($urandom_range(0, 2 * ONE) - ONE);
                    next_setting[2*k+1] = ph_word_t'($urandom_range(0, 2 * ONE) - ONE);
                end
                2:
                begin
                    next_setting[2*k]   = ph_word_t'($urandom);
                    next_setting[2*k+1] = ph_word_t'($urandom);
                end
                default:
                begin
                    for (int j = 0; j < 2; j++)
                    begin
                        case ($urandom_range(0, 4))
                            0:       next_setting[2*k+j] = ph_word_t'(PH_MIN);
                            1:       next_setting[2*k+j] = ph_word_t'(-ONE);
                            2:       next_setting[2*k+j] = ph_word_t'(0);
                            3:       next_setting[2*k+j] = ph_word_t'(ONE);
                            default: next_setting[2*k+j] = ph_word_t'(PH_MAX);
                        endcase
                    end
                end
            endcase
        end
    endtask

    // ---------------------------------------------------------------
    // channel drivers
    // ---------------------------------------------------------------

    // offer one request after an optional gap; return at the accepting edge
    task automatic send_sample(input mix_in_t x, input int gap);
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample       <= x;
        sample_valid <= 1'b1;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // stop offering and wait until every predicted result has come back
    task automatic drain();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write the selected registers back to back; each write reloads the phasors
    task automatic apply_setting(input logic [NUM_REGS-1:0] mask);
        for (int i = 0; i < NUM_REGS; i++)
        begin
            if (mask[i])
            begin
                cfg_valid <= 1'b1;
                cfg_index <= cfg_idx_t'(i);
                cfg_data  <= next_setting[i];
                @(posedge clk);
                while (!cfg_ready)
                    @(posedge clk);
                cfg_writes++;
            end
        end
        cfg_valid <= 1'b0;
        // let the phasor reload land before new requests
        repeat (SETTLE_CYCLES) @(posedge clk);
        settings_used++;
    endtask

    // ---------------------------------------------------------------
    // result sink: random stalls, plus the long hold-off on request
    // ---------------------------------------------------------------
    initial
    begin : result_sink
        int   hold_left;
        int   run_left;
        logic stall_now;
        hold_left = 0;
        run_left  = 0;
        stall_now = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_ask != hold_done)
            begin
                hold_done = hold_ask;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                // counted hold-off: the block fills and pushes back on requests
                hold_left--;
                mixed_stall <= 1'b1;
            end
            else if (run_left > 0)
            begin
                run_left--;
                mixed_stall <= stall_now;
            end
            else
            begin
                stall_now   = !stall_now;
                run_left    = (stall_now ? stall_len() : ready_len()) - 1;
                mixed_stall <= stall_now;
            end
            @(posedge clk);
        end
    end

    // ---------------------------------------------------------------
    // main stimulus
    // ---------------------------------------------------------------
    initial
    begin : stimulus
        int                   gap;
        int                   press_left;
        bit                   no_gaps;
        logic [NUM_REGS-1:0]  mask;
        press_left = 0;

        // single reset at the start
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed: reset setting, unit phasors pass samples through ---
        send_sample(mix_in_t'({8{16'h0000}}), idle_len());
        send_sample(mix_in_t'({8{16'h7FFF}}), idle_len());
        send_sample(mix_in_t'({8{16'h8000}}), idle_len());
        send_sample(mix_in_t'({4{16'h7FFF, 16'h8000}}), idle_len());
        send_sample(mix_in_t'({4{16'h8000, 16'h7FFF}}), idle_len());

        // --- directed: quarter-turn step, lane one at -1.0 (negating full
        // scale saturates), lane two at one half (rounding ties), lane three -j
        drain();
        next_setting = '{0, ONE, -ONE, 0, HALF_ONE, 0, 0, -ONE};
        apply_setting('1);
        send_sample(mix_in_t'({8{16'h8000}}), idle_len());
        send_sample(mix_in_t'({2{16'h0001, 16'hFFFF, 16'h0003, 16'hFFFD}}), idle_len());
        send_sample(mix_in_t'({8{16'h7FFF}}), idle_len());
        send_sample(mix_in_t'({8{16'h8000}}), idle_len());
        send_sample(draw_sample(), idle_len());
        send_sample(draw_sample(), idle_len());

        // --- directed: registers beyond unit magnitude, phasors grow and clip
        drain();
        next_setting = '{PH_MAX, PH_MAX, PH_MIN, PH_MIN, PH_MAX, 0, ONE, ONE};
        apply_setting('1);
        send_sample(mix_in_t'({8{16'h7FFF}}), idle_len());
        send_sample(mix_in_t'({8{16'h7FFF}}), idle_len());
        send_sample(mix_in_t'({8{16'h8000}}), idle_len());
        send_sample(mix_in_t'({8{16'h8000}}), idle_len());
        send_sample(draw_sample(), idle_len());
        send_sample(draw_sample(), idle_len());

        // --- directed: negative step, mixed-sign starts, a zero phasor
        drain();
        next_setting = '{-ONE, -ONE, -ONE, ONE, ONE, -ONE, 0, 0};
        apply_setting('1);
        send_sample(mix_in_t'({4{16'h8000, 16'h7FFF}}), idle_len());
        send_sample(mix_in_t'({8{16'h7FFF}}), idle_len());
        send_sample(draw_sample(), idle_len());
        send_sample(draw_sample(), idle_len());

        // --- random phases, each under a fresh register setting ---
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            draw_setting(ph % 4);
            if (ph == 0)
                mask = '1;
            else if (ph == SINGLE_WRITE_PHASE)
                mask = NUM_REGS'(1) << $urandom_range(0, NUM_REGS - 1);
            else
                mask = NUM_REGS'($urandom_range(1, (1 << NUM_REGS) - 1));
            drain();
            apply_setting(mask);

            no_gaps = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (ph == PRESSURE_PHASE && n == PRESSURE_AT)
                begin
                    // hold results off while requests keep coming back to back
                    hold_ask++;
                    press_left = PRESSURE_ITEMS;
                end
                if (ph == DRAIN_PHASE && n == DRAIN_AT)
                    drain();
                gap = (no_gaps || press_left > 0) ? 0 : idle_len();
                if (press_left > 0)
                    press_left--;
                send_sample(draw_sample(), gap);
            end
        end

        // --- wind down ---
        sample_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d sample requests and %0d mixed results under %0d settings",
                 items_sent, results_seen, settings_used);
        $display("(%0d register writes, long result hold-off, drain pauses, clipping phasors)",
                 cfg_writes);
        if (fails == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/flpm_pkg.sv
rtl/flpm_cfg.sv
rtl/flpm_lane.sv
rtl/four_lane_rotating_phasor_mixer.sv
verif/flpm_mixer_checker.sv
verif/tb_four_lane_rotating_phasor_mixer.sv
